[rtl/core/fac_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fac_pkg
// Shared types, widths and codes of the box versus frustum plane classifier.
// ----------------------------------------------------------------------------
package fac_pkg;

  localparam int NumPlanes  = 6;
  localparam int CoordWidth = 32;
  localparam int NormW      = 18;
  localparam int OffsW      = 32;
  localparam int IdxW       = 3;
  localparam int FracW      = 16;
  localparam int ProdW      = NormW + CoordWidth;
  localparam int OffAlW     = OffsW + FracW;
  // three products plus the aligned offset cannot overflow two extra bits
  localparam int SumW       = ProdW + 2;

  typedef enum logic [0:0] {
    OpLoad = 1'b0,
    OpTest = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    VerdictOutside    = 2'd0,
    VerdictIntersects = 2'd1,
    VerdictInside     = 2'd2
  } verdict_e;

  typedef logic signed [NormW-1:0]      norm_t;
  typedef logic signed [OffsW-1:0]      offs_t;
  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic signed [ProdW-1:0]      prod_t;
  typedef logic signed [OffAlW-1:0]     offal_t;
  typedef logic signed [SumW-1:0]       sum_t;

  // one item as it travels down the row of plane cells
  typedef struct packed {
    op_e                  op;
    logic [IdxW-1:0]      plane_index;
    norm_t                normal_x;
    norm_t                normal_y;
    norm_t                normal_z;
    offs_t                plane_offset;
    coord_t               box_min_x;
    coord_t               box_min_y;
    coord_t               box_min_z;
    coord_t               box_max_x;
    coord_t               box_max_y;
    coord_t               box_max_z;
    logic                 outside;
    logic                 all_in;
  } item_t;

endpackage

[rtl/core/fac_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fac_if
// Valid/ready channels of the classifier: plane load and box test items in,
// verdicts out.
// ----------------------------------------------------------------------------
interface fac_in_if;
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic [fac_pkg::IdxW-1:0]  plane_index;
  fac_pkg::norm_t            normal_x;
  fac_pkg::norm_t            normal_y;
  fac_pkg::norm_t            normal_z;
  fac_pkg::offs_t            plane_offset;
  fac_pkg::coord_t           box_min_x;
  fac_pkg::coord_t           box_min_y;
  fac_pkg::coord_t           box_min_z;
  fac_pkg::coord_t           box_max_x;
  fac_pkg::coord_t           box_max_y;
  fac_pkg::coord_t           box_max_z;

  modport source (
    output valid, op, plane_index, normal_x, normal_y, normal_z, plane_offset,
           box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    input  ready
  );
  modport sink (
    input  valid, op, plane_index, normal_x, normal_y, normal_z, plane_offset,
           box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    output ready
  );
endinterface

interface fac_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;

  modport source (output valid, verdict, input ready);
  modport sink (input valid, verdict, output ready);
endinterface

[rtl/core/fac_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fac_cell
// One plane of the row: holds its normal and offset, takes loads addressed to
// it and folds its two vertex distance signs into each passing test item.
// ----------------------------------------------------------------------------
module fac_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [fac_pkg::IdxW-1:0]  cell_idx_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  fac_pkg::item_t            in_item_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output fac_pkg::item_t            out_item_o
);

  // plane held by this cell
  fac_pkg::norm_t  nrm_q [3];
  fac_pkg::offs_t  off_q;

  // product stage
  logic            a_vld_q, a_vld_d;
  fac_pkg::item_t  a_item_q;
  fac_pkg::prod_t  pp_q [3];
  fac_pkg::prod_t  np_q [3];
  fac_pkg::offs_t  a_off_q;

  // sum and sign stage
  logic            b_vld_q, b_vld_d;
  fac_pkg::item_t  b_item_q, b_item_d;

  logic            a_rdy, b_rdy, a_ld, plane_wr;
  fac_pkg::coord_t bmin [3];
  fac_pkg::coord_t bmax [3];
  fac_pkg::prod_t  pp_d [3];
  fac_pkg::prod_t  np_d [3];
  fac_pkg::sum_t   psum, nsum;
  fac_pkg::offal_t off_al;
  logic            pneg, nneg;

  assign b_rdy      = !b_vld_q || out_ready_i;
  assign a_rdy      = !a_vld_q || b_rdy;
  assign a_ld       = in_valid_i && a_rdy;
  assign in_ready_o = a_rdy;
  assign plane_wr   = a_ld && (in_item_i.op == fac_pkg::OpLoad) &&
                      (in_item_i.plane_index == cell_idx_i);

  assign bmin[0] = in_item_i.box_min_x;
  assign bmin[1] = in_item_i.box_min_y;
  assign bmin[2] = in_item_i.box_min_z;
  assign bmax[0] = in_item_i.box_max_x;
  assign bmax[1] = in_item_i.box_max_y;
  assign bmax[2] = in_item_i.box_max_z;

  // positive vertex takes max where the normal component is nonnegative
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (nrm_q[k][fac_pkg::NormW-1]) begin
        pp_d[k] = fac_pkg::prod_t'(nrm_q[k]) * fac_pkg::prod_t'(bmin[k]);
        np_d[k] = fac_pkg::prod_t'(nrm_q[k]) * fac_pkg::prod_t'(bmax[k]);
      end else begin
        pp_d[k] = fac_pkg::prod_t'(nrm_q[k]) * fac_pkg::prod_t'(bmax[k]);
        np_d[k] = fac_pkg::prod_t'(nrm_q[k]) * fac_pkg::prod_t'(bmin[k]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        nrm_q[k] <= '0;
      end
      off_q <= '0;
    end else if (plane_wr) begin
      nrm_q[0] <= in_item_i.normal_x;
      nrm_q[1] <= in_item_i.normal_y;
      nrm_q[2] <= in_item_i.normal_z;
      off_q    <= in_item_i.plane_offset;
    end
  end

  always_comb begin
    a_vld_d = a_vld_q;
    if (a_rdy) begin
      a_vld_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else begin
      a_vld_q <= a_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ld) begin
      a_item_q <= in_item_i;
      pp_q     <= pp_d;
      np_q     <= np_d;
      a_off_q  <= off_q;
    end
  end

  // offset from Q16.16 up to the Q.32 scale of the products
  assign off_al = fac_pkg::offal_t'({a_off_q, {fac_pkg::FracW{1'b0}}});

  always_comb begin
    psum = fac_pkg::sum_t'(pp_q[0]) + fac_pkg::sum_t'(pp_q[1]) +
           fac_pkg::sum_t'(pp_q[2]) + fac_pkg::sum_t'(off_al);
    nsum = fac_pkg::sum_t'(np_q[0]) + fac_pkg::sum_t'(np_q[1]) +
           fac_pkg::sum_t'(np_q[2]) + fac_pkg::sum_t'(off_al);
    pneg = psum[fac_pkg::SumW-1];
    nneg = nsum[fac_pkg::SumW-1];
    b_item_d = a_item_q;
    if (a_item_q.op == fac_pkg::OpTest) begin
      b_item_d.outside = a_item_q.outside || (pneg && nneg);
      b_item_d.all_in  = a_item_q.all_in && !(pneg || nneg);
    end
  end

  always_comb begin
    b_vld_d = b_vld_q;
    if (b_rdy) begin
      b_vld_d = a_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else begin
      b_vld_q <= b_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_rdy && a_vld_q) begin
      b_item_q <= b_item_d;
    end
  end

  assign out_valid_o = b_vld_q;
  assign out_item_o  = b_item_q;

  a_take_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_ld |=> a_vld_q)
    else $error("accepted item did not reach the product stage");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_vld_q && !b_rdy |=> a_vld_q && $stable(a_item_q))
    else $error("product stage lost its item while stalled");

  flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_item_o.outside && out_item_o.all_in))
    else $error("item marked both outside and fully inside");

  load_flags_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.op == fac_pkg::OpLoad)
      |-> out_item_o.all_in && !out_item_o.outside)
    else $error("load item picked up test flags");

endmodule

[rtl/core/frustum_aabb_cull_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frustum_aabb_cull_test
// Classifies axis-aligned boxes against a table of frustum planes.
// ----------------------------------------------------------------------------
// Items pass down a row of plane cells, one cell per plane, two register
// stages per cell (products, then sum and sign), and then an output register.
// A new item is taken every cycle while the output is not stalled. A plane
// load travels down the row in order with the tests and is written when it
// passes its cell, so a test sees exactly the planes loaded before it. Loads
// and loads to an index beyond the table give no verdict. After reset all
// planes are zero and every box reads as fully inside.
module frustum_aabb_cull_test (
  input  logic clk_i,
  input  logic rst_ni,
  fac_in_if.sink    in_i,
  fac_out_if.source out_o
);

  logic            vld [fac_pkg::NumPlanes+1];
  logic            rdy [fac_pkg::NumPlanes+1];
  fac_pkg::item_t  itm [fac_pkg::NumPlanes+1];

  logic            out_vld_q, out_vld_d, o_rdy;
  logic [1:0]      verdict_q;
  fac_pkg::item_t  tail;

  always_comb begin
    itm[0]              = '0;
    itm[0].op           = fac_pkg::op_e'(in_i.op);
    itm[0].plane_index  = in_i.plane_index;
    itm[0].normal_x     = in_i.normal_x;
    itm[0].normal_y     = in_i.normal_y;
    itm[0].normal_z     = in_i.normal_z;
    itm[0].plane_offset = in_i.plane_offset;
    itm[0].box_min_x    = in_i.box_min_x;
    itm[0].box_min_y    = in_i.box_min_y;
    itm[0].box_min_z    = in_i.box_min_z;
    itm[0].box_max_x    = in_i.box_max_x;
    itm[0].box_max_y    = in_i.box_max_y;
    itm[0].box_max_z    = in_i.box_max_z;
    itm[0].outside      = 1'b0;
    itm[0].all_in       = 1'b1;
  end

  assign vld[0]     = in_i.valid;
  assign in_i.ready = rdy[0];

  for (genvar g = 0; g < fac_pkg::NumPlanes; g++) begin : g_cell
    fac_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cell_idx_i  (fac_pkg::IdxW'(g)),
      .in_valid_i  (vld[g]),
      .in_ready_o  (rdy[g]),
      .in_item_i   (itm[g]),
      .out_valid_o (vld[g+1]),
      .out_ready_i (rdy[g+1]),
      .out_item_o  (itm[g+1])
    );
  end

  // loads leave the row here without a verdict
  assign tail                  = itm[fac_pkg::NumPlanes];
  assign o_rdy                 = !out_vld_q || out_o.ready;
  assign rdy[fac_pkg::NumPlanes] = o_rdy;

  always_comb begin
    out_vld_d = out_vld_q;
    if (o_rdy) begin
      out_vld_d = vld[fac_pkg::NumPlanes] && (tail.op == fac_pkg::OpTest);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (o_rdy && vld[fac_pkg::NumPlanes]) begin
      if (tail.outside) begin
        verdict_q <= fac_pkg::VerdictOutside;
      end else if (tail.all_in) begin
        verdict_q <= fac_pkg::VerdictInside;
      end else begin
        verdict_q <= fac_pkg::VerdictIntersects;
      end
    end
  end

  assign out_o.valid   = out_vld_q;
  assign out_o.verdict = verdict_q;

endmodule

[sim/frustum_aabb_cull_test_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frustum_aabb_cull_test_tb
// Feeds plane loads and box tests into the classifier with random input gaps
// and output stalls. It keeps its own plane table, works out each verdict with
// exact 64-bit distances and checks every verdict against the oldest one due.
// ----------------------------------------------------------------------------
module frustum_aabb_cull_test_tb;

  localparam int StallLimit = 4000;
  localparam int TailCycles = 2 * fac_pkg::NumPlanes + 8;
  localparam int ItemTarget = 650;
  localparam int Unit       = 1 << fac_pkg::FracW;
  localparam int MostNeg    = -2147483647 - 1;
  localparam int MostPos    = 2147483647;
  localparam int NormMin    = -131072;
  localparam int NormMax    = 131071;

  typedef struct {
    fac_pkg::op_e                op;
    logic [fac_pkg::IdxW-1:0]    plane_index;
    fac_pkg::norm_t              normal_x;
    fac_pkg::norm_t              normal_y;
    fac_pkg::norm_t              normal_z;
    fac_pkg::offs_t              plane_offset;
    fac_pkg::coord_t             box_min_x;
    fac_pkg::coord_t             box_min_y;
    fac_pkg::coord_t             box_min_z;
    fac_pkg::coord_t             box_max_x;
    fac_pkg::coord_t             box_max_y;
    fac_pkg::coord_t             box_max_z;
  } cull_item_t;

  class cull_scoreboard;
    fac_pkg::norm_t    normals[fac_pkg::NumPlanes][3];
    fac_pkg::offs_t    offsets[fac_pkg::NumPlanes];
    fac_pkg::verdict_e verdicts_due[$];
    int                mismatches;

    function new();
      foreach (normals[p, k]) normals[p][k] = '0;
      foreach (offsets[p]) offsets[p] = '0;
      mismatches = 0;
    endfunction

    function int pending();
      return verdicts_due.size();
    endfunction

    function fac_pkg::verdict_e classify_box(cull_item_t it);
      longint bmin[3];
      longint bmax[3];
      longint n, dpos, dneg;
      bit     cut_off, all_in;
      bmin[0] = it.box_min_x;
      bmin[1] = it.box_min_y;
      bmin[2] = it.box_min_z;
      bmax[0] = it.box_max_x;
      bmax[1] = it.box_max_y;
      bmax[2] = it.box_max_z;
      cut_off = 1'b0;
      all_in  = 1'b1;
      for (int p = 0; p < fac_pkg::NumPlanes; p++) begin
        // offset aligned to the product scale, sums stay well inside 64 bits
        dpos = longint'(offsets[p]) <<< fac_pkg::FracW;
        dneg = dpos;
        for (int k = 0; k < 3; k++) begin
          n = normals[p][k];
          if (n >= 0) begin
            dpos += n * bmax[k];
            dneg += n * bmin[k];
          end else begin
            dpos += n * bmin[k];
            dneg += n * bmax[k];
          end
        end
        if (dpos < 0 && dneg < 0) cut_off = 1'b1;
        if (dpos < 0 || dneg < 0) all_in = 1'b0;
      end
      if (cut_off) return fac_pkg::VerdictOutside;
      if (all_in) return fac_pkg::VerdictInside;
      return fac_pkg::VerdictIntersects;
    endfunction

    function void note_item(cull_item_t it);
      if (it.op == fac_pkg::OpTest) begin
        verdicts_due = {verdicts_due, classify_box(it)};
      end else if (it.plane_index < fac_pkg::NumPlanes) begin
        normals[it.plane_index][0] = it.normal_x;
        normals[it.plane_index][1] = it.normal_y;
        normals[it.plane_index][2] = it.normal_z;
        offsets[it.plane_index]    = it.plane_offset;
      end
    endfunction

    function void check_verdict(logic [1:0] got);
      fac_pkg::verdict_e want;
      if (verdicts_due.size() == 0) begin
        $error("verdict: expected none, actual %0d", got);
        mismatches++;
      end else begin
        want = verdicts_due.pop_front();
        if (got !== want) begin
          $error("verdict: expected %0d (%s), actual %0d", want, want.name(), got);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic           clk_i;
  logic           rst_ni;
  bit             steady_stretch = 1'b0;
  int             items_sent = 0;
  int             no_progress;
  cull_scoreboard sb = new();

  fac_in_if  in_bus ();
  fac_out_if out_bus ();

  frustum_aabb_cull_test u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // both handshakes sampled on the edge, before any driver update lands
  always @(posedge clk_i) begin : monitor
    cull_item_t seen;
    if (rst_ni === 1'b1) begin
      if (in_bus.valid && in_bus.ready) begin
        seen.op           = fac_pkg::op_e'(in_bus.op);
        seen.plane_index  = in_bus.plane_index;
        seen.normal_x     = in_bus.normal_x;
        seen.normal_y     = in_bus.normal_y;
        seen.normal_z     = in_bus.normal_z;
        seen.plane_offset = in_bus.plane_offset;
        seen.box_min_x    = in_bus.box_min_x;
        seen.box_min_y    = in_bus.box_min_y;
        seen.box_min_z    = in_bus.box_min_z;
        seen.box_max_x    = in_bus.box_max_x;
        seen.box_max_y    = in_bus.box_max_y;
        seen.box_max_z    = in_bus.box_max_z;
        sb.note_item(seen);
      end
      if (out_bus.valid && out_bus.ready) sb.check_verdict(out_bus.verdict);
    end
  end

  // verdict receiver: stalls about one cycle in five, except during the steady stretch
  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_bus.ready <= steady_stretch || ($urandom_range(0, 99) >= 19);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      no_progress <= 0;
    end else if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      no_progress <= 0;
    end else begin
      no_progress <= no_progress + 1;
    end
  end

  initial begin
    do @(posedge clk_i); while (no_progress < StallLimit);
    $display("[frustum_aabb_cull_test] ERROR");
    $finish;
  end

  function automatic cull_item_t noise_item();
    cull_item_t it;
    it.op           = fac_pkg::op_e'($urandom_range(0, 1));
    it.plane_index  = fac_pkg::IdxW'($urandom_range(0, 7));
    it.normal_x     = fac_pkg::norm_t'($urandom);
    it.normal_y     = fac_pkg::norm_t'($urandom);
    it.normal_z     = fac_pkg::norm_t'($urandom);
    it.plane_offset = fac_pkg::offs_t'($urandom);
    it.box_min_x    = fac_pkg::coord_t'($urandom);
    it.box_min_y    = fac_pkg::coord_t'($urandom);
    it.box_min_z    = fac_pkg::coord_t'($urandom);
    it.box_max_x    = fac_pkg::coord_t'($urandom);
    it.box_max_y    = fac_pkg::coord_t'($urandom);
    it.box_max_z    = fac_pkg::coord_t'($urandom);
    return it;
  endfunction

  // unused fields keep random content
  function automatic cull_item_t load_item(int idx, int nx, int ny, int nz, int off);
    cull_item_t it;
    it              = noise_item();
    it.op           = fac_pkg::OpLoad;
    it.plane_index  = fac_pkg::IdxW'(idx);
    it.normal_x     = fac_pkg::norm_t'(nx);
    it.normal_y     = fac_pkg::norm_t'(ny);
    it.normal_z     = fac_pkg::norm_t'(nz);
    it.plane_offset = fac_pkg::offs_t'(off);
    return it;
  endfunction

  function automatic cull_item_t box_item(int x0, int y0, int z0, int x1, int y1, int z1);
    cull_item_t it;
    it           = noise_item();
    it.op        = fac_pkg::OpTest;
    it.box_min_x = fac_pkg::coord_t'(x0);
    it.box_min_y = fac_pkg::coord_t'(y0);
    it.box_min_z = fac_pkg::coord_t'(z0);
    it.box_max_x = fac_pkg::coord_t'(x1);
    it.box_max_y = fac_pkg::coord_t'(y1);
    it.box_max_z = fac_pkg::coord_t'(z1);
    return it;
  endfunction

  function automatic int frame_normal();
    if ($urandom_range(0, 7) == 0) return ($urandom_range(0, 1) != 0) ? NormMax : NormMin;
    return int'($urandom_range(0, 2 * Unit)) - Unit;
  endfunction

  task automatic send_item(cull_item_t it);
    while (!steady_stretch && $urandom_range(0, 99) < 19) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid        <= 1'b1;
    in_bus.op           <= it.op;
    in_bus.plane_index  <= it.plane_index;
    in_bus.normal_x     <= it.normal_x;
    in_bus.normal_y     <= it.normal_y;
    in_bus.normal_z     <= it.normal_z;
    in_bus.plane_offset <= it.plane_offset;
    in_bus.box_min_x    <= it.box_min_x;
    in_bus.box_min_y    <= it.box_min_y;
    in_bus.box_min_z    <= it.box_min_z;
    in_bus.box_max_x    <= it.box_max_x;
    in_bus.box_max_y    <= it.box_max_y;
    in_bus.box_max_z    <= it.box_max_z;
    do @(posedge clk_i); while (!in_bus.ready);
    if (!(it.op == fac_pkg::OpLoad && it.plane_index >= fac_pkg::NumPlanes)) items_sent++;
  endtask

  // the edge of the last acceptance is skipped, the monitor notes it there
  task automatic wait_results();
    in_bus.valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // reload the planes around the origin (a partial frame skips some), then test boxes near them
  task automatic run_frame();
    int              u, first, dir, p, cx, cy, cz, hx, hy, hz;
    bit              partial;
    fac_pkg::coord_t tmp;
    cull_item_t      it;
    u       = 1 << $urandom_range(10, 22);
    first   = $urandom_range(0, fac_pkg::NumPlanes - 1);
    dir     = ($urandom_range(0, 1) != 0) ? 1 : fac_pkg::NumPlanes - 1;
    partial = ($urandom_range(0, 3) == 0);
    for (int k = 0; k < fac_pkg::NumPlanes; k++) begin
      p = (first + k * dir) % fac_pkg::NumPlanes;
      if (!(partial && $urandom_range(0, 4) == 0)) begin
        send_item(load_item(p, frame_normal(), frame_normal(), frame_normal(),
                            int'($urandom_range(1, 8)) * u + int'($urandom_range(0, u - 1))));
      end
      if ($urandom_range(0, 15) == 0) begin
        it             = noise_item();
        it.op          = fac_pkg::OpLoad;
        it.plane_index = fac_pkg::IdxW'($urandom_range(fac_pkg::NumPlanes, 7));
        send_item(it);
      end
    end
    repeat ($urandom_range(4, 14)) begin
      cx = (int'($urandom_range(0, 24)) - 12) * u + int'($urandom_range(0, u - 1));
      cy = (int'($urandom_range(0, 24)) - 12) * u + int'($urandom_range(0, u - 1));
      cz = (int'($urandom_range(0, 24)) - 12) * u + int'($urandom_range(0, u - 1));
      hx = $urandom_range(0, 4 * u);
      hy = $urandom_range(0, 4 * u);
      hz = $urandom_range(0, 4 * u);
      it = box_item(cx - hx, cy - hy, cz - hz, cx + hx, cy + hy, cz + hz);
      if ($urandom_range(0, 9) == 0) begin
        tmp          = it.box_min_y;
        it.box_min_y = it.box_max_y;
        it.box_max_y = tmp;
      end
      send_item(it);
    end
  endtask

  initial begin
    bit drained;
    drained                = 1'b0;
    rst_ni              <= 1'b0;
    in_bus.valid        <= 1'b0;
    in_bus.op           <= fac_pkg::OpLoad;
    in_bus.plane_index  <= '0;
    in_bus.normal_x     <= '0;
    in_bus.normal_y     <= '0;
    in_bus.normal_z     <= '0;
    in_bus.plane_offset <= '0;
    in_bus.box_min_x    <= '0;
    in_bus.box_min_y    <= '0;
    in_bus.box_min_z    <= '0;
    in_bus.box_max_x    <= '0;
    in_bus.box_max_y    <= '0;
    in_bus.box_max_z    <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fresh table: any box, inverted or not, is fully inside
    send_item(box_item(MostNeg, MostNeg, MostNeg, MostPos, MostPos, MostPos));
    send_item(box_item(MostPos, MostPos, MostPos, MostNeg, MostNeg, MostNeg));
    // loads past the end of the table are dropped
    send_item(load_item(fac_pkg::NumPlanes, Unit, 0, 0, -5 * Unit));
    send_item(load_item(7, Unit, 0, 0, -5 * Unit));
    send_item(box_item(-Unit, -Unit, -Unit, Unit, Unit, Unit));

    // cube of half width ten
    send_item(load_item(0, Unit, 0, 0, 10 * Unit));
    send_item(load_item(1, -Unit, 0, 0, 10 * Unit));
    send_item(load_item(2, 0, Unit, 0, 10 * Unit));
    send_item(load_item(3, 0, -Unit, 0, 10 * Unit));
    send_item(load_item(4, 0, 0, Unit, 10 * Unit));
    send_item(load_item(5, 0, 0, -Unit, 10 * Unit));
    send_item(box_item(-Unit, -Unit, -Unit, Unit, Unit, Unit));
    send_item(box_item(5 * Unit, -Unit, -Unit, 15 * Unit, Unit, Unit));
    send_item(box_item(20 * Unit, -Unit, -Unit, 30 * Unit, Unit, Unit));
    // touching the face exactly is still inside, one lsb past it is not
    send_item(box_item(0, 0, 0, 10 * Unit, 10 * Unit, 10 * Unit));
    send_item(box_item(0, 0, 0, 10 * Unit + 1, Unit, Unit));
    send_item(box_item(-Unit, -30 * Unit, -Unit, Unit, -20 * Unit, Unit));
    send_item(box_item(5 * Unit, -Unit, -Unit, -5 * Unit, Unit, Unit));

    // extreme normals and offsets against extreme corners
    send_item(load_item(0, NormMin, NormMax, 0, MostNeg));
    send_item(load_item(1, NormMax, NormMin, NormMax, MostPos));
    send_item(box_item(MostNeg, MostNeg, MostNeg, MostPos, MostPos, MostPos));
    send_item(box_item(MostPos, MostPos, MostPos, MostPos, MostPos, MostPos));
    send_item(box_item(MostNeg, MostNeg, MostNeg, MostNeg, MostNeg, MostNeg));

    while (items_sent < ItemTarget) begin
      steady_stretch = (items_sent >= 250 && items_sent < 380);
      if (!drained && items_sent >= 450) begin
        wait_results();
        drained = 1'b1;
      end
      if ($urandom_range(0, 99) < 15) begin
        send_item(noise_item());
      end else begin
        run_frame();
      end
    end
    steady_stretch = 1'b0;

    wait_results();
    repeat (TailCycles) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[frustum_aabb_cull_test] OK");
    end else begin
      $display("[frustum_aabb_cull_test] ERROR");
    end
    $finish;
  end

endmodule
